/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/msd_pkg.sv */
// Shared types and constants for the masked sum of squared differences block.
package msd_pkg;

  localparam int WORD_W    = 64;
  localparam int PIX_W     = 8;
  localparam int SQ_W      = 2 * PIX_W;
  localparam int TOTAL_W   = 64;
  localparam int LANES_MAX = 8;
  localparam int LANES_DEF = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MASKED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_INDEX = 1'd1;

  typedef struct packed {
    logic             masked_mode;
    logic [PIX_W-1:0] match_index;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic last;
  } stage_ctl_t;

endpackage

/* rtl/msd_if.sv */
// Valid/ready channel interfaces for pixel groups and frame totals.
interface msd_in_if;
  logic                           valid;
  logic                           ready;
  logic [msd_pkg::WORD_W-1:0]     a_pixels;
  logic [msd_pkg::WORD_W-1:0]     b_pixels;
  logic [msd_pkg::WORD_W-1:0]     mask_bytes;
  logic [msd_pkg::LANES_MAX-1:0]  lane_valid;
  logic                           frame_end;

  modport source (output valid, a_pixels, b_pixels, mask_bytes, lane_valid, frame_end,
                  input ready);
  modport sink (input valid, a_pixels, b_pixels, mask_bytes, lane_valid, frame_end,
                output ready);
endinterface

interface msd_out_if;
  logic                        valid;
  logic                        ready;
  logic [msd_pkg::TOTAL_W-1:0] ssd_total;

  modport source (output valid, ssd_total, input ready);
  modport sink (input valid, ssd_total, output ready);
endinterface

/* rtl/msd_lane.sv */
// One lane: masked absolute difference and square of a pixel pair.
`include "assert_macros.svh"

module msd_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  msd_pkg::cfg_t               cfg,
  input  logic                        lane_on,
  input  logic [msd_pkg::PIX_W-1:0]   a_pix,
  input  logic [msd_pkg::PIX_W-1:0]   b_pix,
  input  logic [msd_pkg::PIX_W-1:0]   mask_pix,
  output logic [msd_pkg::SQ_W-1:0]    sq
);

  logic                       count;
  logic [msd_pkg::PIX_W-1:0]  diff;
  logic [msd_pkg::SQ_W-1:0]   sq_nxt;
  logic [msd_pkg::SQ_W-1:0]   sq_r;

  always_comb begin
    count  = lane_on && (!cfg.masked_mode || (mask_pix == cfg.match_index));
    diff   = (a_pix > b_pix) ? (a_pix - b_pix) : (b_pix - a_pix);
    sq_nxt = count ? (msd_pkg::SQ_W'(diff) * msd_pkg::SQ_W'(diff)) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

  `ASSERT_CLK(a_lane_drop_zero, (en && !count) |=> (sq_r == '0), "dropped lane not zero")
  `ASSERT_CLK(a_lane_hold, !en |=> $stable(sq_r), "lane square changed while stalled")

endmodule

/* rtl/msd_merge.sv */
// Lane merge: registered adder tree, 64-bit accumulator and result register.
`include "assert_macros.svh"

module msd_merge #(
  parameter int LANES = msd_pkg::LANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  msd_pkg::stage_ctl_t           ctl_in,
  input  logic [msd_pkg::SQ_W-1:0]      sq [LANES],
  output logic                          out_valid,
  output logic [msd_pkg::TOTAL_W-1:0]   out_total
);

  localparam int SUM_W = msd_pkg::SQ_W + $clog2(LANES);

  logic [SUM_W-1:0]             sum_nxt;
  logic [SUM_W-1:0]             sum_r;
  msd_pkg::stage_ctl_t          ctl_r;
  logic [msd_pkg::TOTAL_W-1:0]  acc;
  logic [msd_pkg::TOTAL_W-1:0]  total_r;
  logic [msd_pkg::TOTAL_W-1:0]  total_nxt;
  logic                         out_vld_r;
  logic [msd_pkg::TOTAL_W-1:0]  out_total_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl_r.last <= ctl_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    acc       = total_r + msd_pkg::TOTAL_W'(sum_r);
    total_nxt = total_r;
    if (en && ctl_r.vld) begin
      total_nxt = ctl_r.last ? '0 : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      if (en) begin
        out_vld_r <= ctl_r.vld && ctl_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl_r.vld && ctl_r.last) begin
      out_total_r <= acc;
    end
  end

  assign out_valid = out_vld_r;
  assign out_total = out_total_r;

  `ASSERT_CLK(a_clear_on_end, (en && ctl_r.vld && ctl_r.last) |=> (total_r == '0),
              "total not cleared after frame end")
  `ASSERT_CLK(a_out_from_end, $rose(out_vld_r) |-> $past(en && ctl_r.vld && ctl_r.last),
              "result raised without frame end")
  `ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_vld_r && !ctl_r.vld && (total_r == '0)),
                 "reset did not clear control state")

endmodule

/* rtl/masked_sum_squared_diff_u8.sv */
// Top level: masked sum of squared differences over 8-bit images.
// Takes one group of LANES pixel pairs per transaction, one transaction per
// clock, and returns one 64-bit total (wrapping) on each group marked
// frame_end, counting that group's own lanes. A result passes the lane square
// register, the adder tree register and the accumulator/result register after
// its group is accepted. Input is held off only while a finished result waits
// to be taken. Write configuration only while idle.
module masked_sum_squared_diff_u8 #(
  parameter int LANES = msd_pkg::LANES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  msd_in_if.sink                           in_ch,
  msd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  msd_pkg::cfg_t        cfg_r;
  msd_pkg::stage_ctl_t  ctl_r;
  logic                 en;
  logic [msd_pkg::SQ_W-1:0] sq [LANES];

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        msd_pkg::CFG_MASKED_MODE: cfg_r.masked_mode <= cfg_wdata[0];
        msd_pkg::CFG_MATCH_INDEX: cfg_r.match_index <= cfg_wdata[msd_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= in_ch.valid;
    end
    if (en) begin
      ctl_r.last <= in_ch.frame_end;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    msd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cfg      (cfg_r),
      .lane_on  (in_ch.lane_valid[i]),
      .a_pix    (in_ch.a_pixels[msd_pkg::PIX_W*i +: msd_pkg::PIX_W]),
      .b_pix    (in_ch.b_pixels[msd_pkg::PIX_W*i +: msd_pkg::PIX_W]),
      .mask_pix (in_ch.mask_bytes[msd_pkg::PIX_W*i +: msd_pkg::PIX_W]),
      .sq       (sq[i])
    );
  end

  msd_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl_r),
    .sq        (sq),
    .out_valid (out_ch.valid),
    .out_total (out_ch.ssd_total)
  );

endmodule
